FILE: sv/cif_pkg.sv
// ----------------------------------------------------------------------------
// cif_pkg
// shared types and constants of the card tokenizer and fold block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cif_pkg;

   localparam int COUNT_W = 11;

   // card limit reset value and hard ceiling on card size
   localparam logic [COUNT_W-1:0] CARD_LIMIT_RESET = 11'd1024;
   localparam logic [COUNT_W-1:0] MAX_CARD_BYTES   = 11'd1024;

   // request kinds
   localparam logic FUNC_DATA = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   // one result item
   typedef struct packed {
      logic               event_kind;
      logic [63:0]        token_value;
      logic [1:0]         card_status;
      logic [63:0]        card_fold;
      logic [COUNT_W-1:0] card_bytes;
      logic               last;
   } result_type;

   // results produced by one request: none, first only, or first and second
   typedef struct packed {
      logic one;
      logic two;
   } push_type;

endpackage

FILE: sv/cif_scan.sv
// ----------------------------------------------------------------------------
// cif_scan
// per-byte fnv-1a fold, byte count and signed decimal token scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cif_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         func,
   input  logic [7:0]                   octet,
   input  logic [cif_pkg::COUNT_W-1:0]  limit,
   output cif_pkg::push_type            push,
   output cif_pkg::result_type          res_a,
   output cif_pkg::result_type          res_b
);

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_MINUS  = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_PARSE = 2'd1;
   localparam logic [1:0] ST_SIZE  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam logic KIND_TOKEN   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [63:0] FOLD_BASIS    = 64'd14695981039346656037;
   localparam logic [63:0] FOLD_PRIME_LO = 64'h1B3;   // prime is 2^40 + 0x1b3
   localparam logic [63:0] MAG_TEN_LIMIT = 64'd922337203685477580;
   localparam logic [63:0] MAG_MAX       = 64'd9223372036854775807;

   logic [1:0]                  phase_ff, phase_in;
   logic                        minus_ff, minus_in;
   logic [63:0]                 mag_ff, mag_in;
   logic [63:0]                 fold_ff, fold_in;
   logic [cif_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        fail_ff, fail_in;
   logic                        size_ff, size_in;

   logic        digit;
   logic        space;
   logic        between;
   logic        tok_done;
   logic        end_tok;
   logic [63:0] dval;
   logic [63:0] mag_x10;
   logic [63:0] fold_x;
   logic [63:0] tok_val;
   logic [1:0]  status;
   cif_pkg::result_type tok_res;
   cif_pkg::result_type sum_res;

   assign digit   = (octet >= 8'h30) && (octet <= 8'h39);
   assign space   = (octet == 8'h20) || (octet == 8'h09) || (octet == 8'h0D)
                 || (octet == 8'h0A);
   assign dval    = {60'd0, octet[3:0]};
   assign mag_x10 = {mag_ff[60:0], 3'b000} + {mag_ff[62:0], 1'b0} + dval;
   assign fold_x  = fold_ff ^ {56'd0, octet};
   assign tok_val = minus_ff ? (~mag_ff + 64'd1) : mag_ff;

   // status priority: size, empty, parse, ok
   always_comb begin
      if (size_ff)
         status = ST_SIZE;
      else if (count_ff == '0)
         status = ST_EMPTY;
      else if (fail_ff || (phase_ff == PH_MINUS))
         status = ST_PARSE;
      else
         status = ST_OK;
   end

   always_comb begin
      tok_res             = '0;
      tok_res.event_kind  = KIND_TOKEN;
      tok_res.token_value = tok_val;
      tok_res.last        = 1'b1;
      sum_res             = '0;
      sum_res.event_kind  = KIND_SUMMARY;
      sum_res.card_status = status;
      sum_res.card_fold   = fold_ff;
      sum_res.card_bytes  = count_ff;
      sum_res.last        = 1'b1;
   end

   assign end_tok = !fail_ff && !size_ff && (phase_ff == PH_DIGITS);

   always_comb begin
      phase_in = phase_ff;
      minus_in = minus_ff;
      mag_in   = mag_ff;
      fold_in  = fold_ff;
      count_in = count_ff;
      fail_in  = fail_ff;
      size_in  = size_ff;
      between  = 1'b0;
      tok_done = 1'b0;
      push     = '0;
      res_a    = tok_res;
      res_b    = sum_res;
      if (accept) begin
         if (func == cif_pkg::FUNC_DATA) begin
            if (count_ff >= limit) begin
               size_in = 1'b1;
            end else begin
               fold_in  = {fold_x[23:0], 40'd0} + 64'(fold_x * FOLD_PRIME_LO);
               count_in = count_ff + 11'd1;
               if (!fail_ff) begin
                  unique case (phase_ff)
                     PH_DIGITS: begin
                        if (digit) begin
                           if (mag_ff > MAG_TEN_LIMIT) begin
                              fail_in = 1'b1;
                           end else begin
                              mag_in = mag_x10;
                              if (mag_x10 > MAG_MAX)
                                 fail_in = 1'b1;
                           end
                        end else begin
                           tok_done = 1'b1;
                           phase_in = PH_IDLE;
                           between  = 1'b1;
                        end
                     end
                     PH_MINUS: begin
                        if (digit) begin
                           mag_in   = dval;
                           phase_in = PH_DIGITS;
                        end else begin
                           fail_in = 1'b1;
                        end
                     end
                     default: between = 1'b1;
                  endcase
                  // token ending byte is rescanned from between tokens
                  if (between) begin
                     if (space) begin
                        phase_in = PH_IDLE;
                     end else if (octet == 8'h2D) begin
                        minus_in = 1'b1;
                        mag_in   = '0;
                        phase_in = PH_MINUS;
                     end else if (digit) begin
                        minus_in = 1'b0;
                        mag_in   = dval;
                        phase_in = PH_DIGITS;
                     end else begin
                        fail_in = 1'b1;
                     end
                  end
                  push.one = tok_done;
               end
            end
         end else begin
            // end of card: optional pending token, then summary, then clear
            push.one = 1'b1;
            push.two = end_tok;
            if (end_tok) begin
               res_a      = tok_res;
               res_a.last = 1'b0;
            end else begin
               res_a = sum_res;
            end
            phase_in = PH_IDLE;
            minus_in = 1'b0;
            mag_in   = '0;
            fold_in  = FOLD_BASIS;
            count_in = '0;
            fail_in  = 1'b0;
            size_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         minus_ff <= 1'b0;
         mag_ff   <= '0;
         fold_ff  <= FOLD_BASIS;
         count_ff <= '0;
         fail_ff  <= 1'b0;
         size_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         minus_ff <= minus_in;
         mag_ff   <= mag_in;
         fold_ff  <= fold_in;
         count_ff <= count_in;
         fail_ff  <= fail_in;
         size_ff  <= size_in;
      end
   end

endmodule

FILE: sv/cif_rsp_queue.sv
// ----------------------------------------------------------------------------
// cif_rsp_queue
// four-entry result queue, takes up to two results a cycle, gives one while out_ready is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cif_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  cif_pkg::push_type   push,
   input  cif_pkg::result_type wr_a,
   input  cif_pkg::result_type wr_b,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output cif_pkg::result_type out_data
);

   cif_pkg::result_type entry_ff [4];

   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;
   logic [2:0] n_push;

   assign room      = (count_ff <= 3'd2);
   assign out_valid = (count_ff != 3'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign n_push    = {1'b0, push.one && push.two, push.one && !push.two};

   always_comb begin
      wr_ptr_in = wr_ptr_ff + n_push[1:0];
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + n_push - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (push.one)
         entry_ff[wr_ptr_ff] <= wr_a;
      if (push.one && push.two)
         entry_ff[wr_ptr_ff + 2'd1] <= wr_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/card_integer_tokenizer_fold.sv
// ----------------------------------------------------------------------------
// card_integer_tokenizer_fold: fnv-1a 64 fold and decimal tokenizer per card
// results are written to the four-entry result queue as their request is taken
// throughput: one request per cycle while the queue has room; card end with a pending
//    token makes two results, which drain one per cycle while rsp_tready is high
// reset: synchronous, clears the card state and queue, card limit to 1024
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module card_integer_tokenizer_fold (
   input  logic          clock,
   input  logic          reset,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] octet
   input  logic [0:0]    req_tuser,   // [0] func
   // result channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [143:0]  rsp_tdata,   // [63:0] token_value, [65:64] card_status,
                                      // [129:66] card_fold, [140:130] card_bytes,
                                      // [143:141] zero
   output logic [0:0]    rsp_tuser,   // [0] event_kind
   output logic          rsp_tlast,   // last result of a request
   // card limit register
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [10:0]   csr_wdata    // card_limit
);

   logic [cif_pkg::COUNT_W-1:0] limit_ff;
   logic [cif_pkg::COUNT_W-1:0] limit_eff;
   logic                        accept;
   logic                        room;
   cif_pkg::push_type           push;
   cif_pkg::result_type         res_a;
   cif_pkg::result_type         res_b;
   cif_pkg::result_type         head;

   // register writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset)
         limit_ff <= cif_pkg::CARD_LIMIT_RESET;
      else if (csr_valid)
         limit_ff <= csr_wdata;
   end

   // clamp the limit into 1 .. max card bytes
   always_comb begin
      if (limit_ff == '0)
         limit_eff = 11'd1;
      else if (limit_ff > cif_pkg::MAX_CARD_BYTES)
         limit_eff = cif_pkg::MAX_CARD_BYTES;
      else
         limit_eff = limit_ff;
   end

   // a request is taken while the queue can hold two more results
   assign req_tready = room;
   assign accept     = req_tvalid && room;

   // fold, count and scan state, one request per cycle while the queue has room
   cif_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .func   (req_tuser[0]),
      .octet  (req_tdata),
      .limit  (limit_eff),
      .push   (push),
      .res_a  (res_a),
      .res_b  (res_b)
   );

   // result queue decouples the two sides
   cif_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_a      (res_a),
      .wr_b      (res_b),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {3'd0, head.card_bytes, head.card_fold, head.card_status,
                       head.token_value};
   assign rsp_tuser = head.event_kind;
   assign rsp_tlast = head.last;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: card tokenizer and fold testbench
// drives text cards byte by byte through the request stream and checks every
// token and end-of-card summary against a cycle-free model of the scanner,
// the fnv-1a 64 fold and the byte count, over several card limit settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1600;
   localparam int PHASE_ITEMS  = 60;
   localparam int MAX_PRINTS   = 40;

   // fold and magnitude constants
   localparam logic [63:0] FNV_BASIS = 64'd14695981039346656037;
   localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
   localparam logic [63:0] TEN_LIMIT = 64'd922337203685477580;
   localparam logic [63:0] MAG_MAX   = 64'd9223372036854775807;

   // summary status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_PARSE = 2'd1;
   localparam logic [1:0] STAT_SIZE  = 2'd2;
   localparam logic [1:0] STAT_EMPTY = 2'd3;

   // result kinds
   localparam logic EV_TOKEN   = 1'b0;
   localparam logic EV_SUMMARY = 1'b1;

   // characters the scanner cares about
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef enum logic [1:0] {SCAN_BETWEEN, SCAN_MINUS, SCAN_DIGITS} scan_phase_type;
   typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_SPARSE, STALL_LONG}
      stall_mode_type;
   typedef enum logic [1:0] {PIN_NONE, PIN_TOKEN, PIN_STATUS} pin_kind_type;

   // one row of the opening script; want overrides the token value or the
   // status of the results this request causes
   typedef struct packed {
      logic         func;
      logic [7:0]   octet;
      pin_kind_type pin;
      logic [63:0]  want;
   } script_row_type;

   logic          clock = 1'b0;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [7:0]    req_tdata;   // [7:0] octet
   logic [0:0]    req_tuser;   // [0] func
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [143:0]  rsp_tdata;   // [63:0] token_value, [65:64] card_status,
                               // [129:66] card_fold, [140:130] card_bytes, [143:141] zero
   logic [0:0]    rsp_tuser;   // [0] event_kind
   logic          rsp_tlast;
   logic          csr_valid;
   logic          csr_ready;
   logic [10:0]   csr_wdata;

   card_integer_tokenizer_fold dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // model state of the card scanner and fold
   // ------------------------------------------------------------------------
   logic [10:0]     limit_shadow;
   scan_phase_type  scan_ph;
   logic            neg_sign;
   logic [63:0]     magnitude;
   logic [63:0]     fold;
   logic [10:0]     nbytes;
   logic            failed;
   logic            oversize;

   // tokens and summaries still to come out of the block, oldest first
   cif_pkg::result_type due_events[$];

   // bytes of the card being built
   logic [7:0]   card_text[$];

   int mismatches = 0;
   int n_checked = 0;
   int n_requests = 0;
   int n_tokens = 0;
   int n_summaries = 0;
   int n_oversize = 0;
   int n_parse_fail = 0;
   int n_limit_writes = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int stall_left = 0;
   stall_mode_type stall_mode = STALL_NONE;

   // card limits per phase: zero clamps up to one, 2047 clamps down to 1024
   logic [10:0] phase_limits [0:7] = '{11'd0, 11'd2047, 11'd1, 11'd12,
                                       11'd1025, 11'd30, 11'd3, 11'd1024};

   // numbers at and around the edge of the signed 64-bit range
   string extreme_values [0:5] = '{"9223372036854775807", "9223372036854775808",
                                   "9223372036854775810", "99999999999999999999",
                                   "0000000000000000000042", "18446744073709551616"};

   // short cards covering each scanner case, under the reset limit
   script_row_type opening_script [0:24] = '{
      // empty card right after reset
      '{cif_pkg::FUNC_END,  8'h00,    PIN_STATUS, 64'(STAT_EMPTY)},
      // minus right after digits closes 12 and opens -3
      '{cif_pkg::FUNC_DATA, "1",      PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_DATA, "2",      PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_DATA, CH_MINUS, PIN_TOKEN,  64'd12},
      '{cif_pkg::FUNC_DATA, "3",      PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_END,  8'h00,    PIN_STATUS, 64'(STAT_OK)},
      // stray bytes at both ends of the octet range
      '{cif_pkg::FUNC_DATA, 8'hFF,    PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_DATA, 8'h00,    PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_END,  8'h00,    PIN_STATUS, 64'(STAT_PARSE)},
      // lone minus cut off by card end
      '{cif_pkg::FUNC_DATA, CH_MINUS, PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_END,  8'hFF,    PIN_STATUS, 64'(STAT_PARSE)},
      // whitespace only is a good card
      '{cif_pkg::FUNC_DATA, CH_SPACE, PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_DATA, CH_TAB,   PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_DATA, CH_CR,    PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_DATA, CH_LF,    PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_END,  8'h00,    PIN_STATUS, 64'(STAT_OK)},
      // stray byte right after digits: token first, then the failure
      '{cif_pkg::FUNC_DATA, "7",      PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_DATA, "a",      PIN_TOKEN,  64'd7},
      '{cif_pkg::FUNC_END,  8'h00,    PIN_STATUS, 64'(STAT_PARSE)},
      // minus followed by whitespace
      '{cif_pkg::FUNC_DATA, CH_MINUS, PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_DATA, CH_SPACE, PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_END,  8'h00,    PIN_STATUS, 64'(STAT_PARSE)},
      // negative zero left pending at card end
      '{cif_pkg::FUNC_DATA, CH_MINUS, PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_DATA, "0",      PIN_NONE,   64'd0},
      '{cif_pkg::FUNC_END,  8'h00,    PIN_TOKEN,  64'd0}
   };

   function automatic void clear_card();
      scan_ph   = SCAN_BETWEEN;
      neg_sign  = 1'b0;
      magnitude = 64'd0;
      fold      = FNV_BASIS;
      nbytes    = 11'd0;
      failed    = 1'b0;
      oversize  = 1'b0;
   endfunction

   function automatic cif_pkg::result_type token_event(input logic neg,
                                                       input logic [63:0] mag,
                                                       input logic last_flag);
      cif_pkg::result_type r;
      r             = '0;
      r.event_kind  = EV_TOKEN;
      r.token_value = neg ? (~mag + 64'd1) : mag;
      r.last        = last_flag;
      return r;
   endfunction

   // advance the scanner by one accepted byte; high when a token just closed
   function automatic logic scan_octet(input logic [7:0] c);
      logic is_digit;
      logic closed;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      closed   = 1'b0;
      if (failed)
         return 1'b0;
      if (scan_ph == SCAN_DIGITS) begin
         if (is_digit) begin
            // a tenth of the ceiling checked first keeps the multiply from wrapping
            if (magnitude > TEN_LIMIT)
               failed = 1'b1;
            else begin
               magnitude = magnitude * 64'd10 + 64'(c - CH_ZERO);
               if (magnitude > MAG_MAX)
                  failed = 1'b1;
            end
            return 1'b0;
         end
         closed  = 1'b1;
         scan_ph = SCAN_BETWEEN;
      end else if (scan_ph == SCAN_MINUS) begin
         if (is_digit) begin
            magnitude = 64'(c - CH_ZERO);
            scan_ph   = SCAN_DIGITS;
         end else
            failed = 1'b1;
         return 1'b0;
      end
      // the closing byte is handled again from between tokens
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
      end else if (c == CH_MINUS) begin
         neg_sign  = 1'b1;
         magnitude = 64'd0;
         scan_ph   = SCAN_MINUS;
      end else if (is_digit) begin
         neg_sign  = 1'b0;
         magnitude = 64'(c - CH_ZERO);
         scan_ph   = SCAN_DIGITS;
      end else
         failed = 1'b1;
      return closed;
   endfunction

   // work out the results of one request and queue them
   task automatic fold_and_scan(input logic func, input logic [7:0] c);
      logic [10:0]         eff;
      logic                keep_neg;
      logic [63:0]         keep_mag;
      cif_pkg::result_type s;
      eff = (limit_shadow == 11'd0) ? 11'd1 :
            (limit_shadow > cif_pkg::MAX_CARD_BYTES) ? cif_pkg::MAX_CARD_BYTES
                                                     : limit_shadow;
      if (func == cif_pkg::FUNC_DATA) begin
         if (nbytes >= eff) begin
            oversize = 1'b1;
            return;
         end
         fold     = (fold ^ {56'd0, c}) * FNV_PRIME;
         nbytes   = nbytes + 11'd1;
         keep_neg = neg_sign;
         keep_mag = magnitude;
         if (scan_octet(c)) begin
            due_events.push_back(token_event(keep_neg, keep_mag, 1'b1));
            n_tokens++;
         end
         return;
      end
      // card end: a dangling minus fails, a pending token goes out unless cut or failed
      if (!failed && scan_ph == SCAN_MINUS)
         failed = 1'b1;
      if (!failed && !oversize && scan_ph == SCAN_DIGITS) begin
         due_events.push_back(token_event(neg_sign, magnitude, 1'b0));
         n_tokens++;
      end
      s            = '0;
      s.event_kind = EV_SUMMARY;
      s.card_fold  = fold;
      s.card_bytes = nbytes;
      s.last       = 1'b1;
      if (oversize) begin
         s.card_status = STAT_SIZE;
         n_oversize++;
      end else if (nbytes == 11'd0)
         s.card_status = STAT_EMPTY;
      else if (failed) begin
         s.card_status = STAT_PARSE;
         n_parse_fail++;
      end else
         s.card_status = STAT_OK;
      due_events.push_back(s);
      n_summaries++;
      clear_card();
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("tb: result %0d, %s: got %h, want %h", n_checked, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // request side: bursts of back-to-back requests with random gaps
   // called and returns at a falling edge; within a burst tvalid stays high between requests
   // ------------------------------------------------------------------------
   task automatic send_request(input logic func, input logic [7:0] octet,
                               input pin_kind_type pin, input logic [63:0] want);
      int                  first;
      cif_pkg::result_type r;
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
         // now and then a long burst with no gap at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser  = func;
      req_tdata  = octet;
      do @(posedge clock); while (!req_tready);
      // request taken at this edge
      first = due_events.size();
      fold_and_scan(func, octet);
      n_requests++;
      // typed-in values from the opening script replace the model's
      if (pin == PIN_TOKEN) begin
         r             = due_events[first];
         r.token_value = want;
         due_events[first] = r;
      end else if (pin == PIN_STATUS) begin
         r             = due_events[due_events.size() - 1];
         r.card_status = want[1:0];
         due_events[due_events.size() - 1] = r;
      end
      @(negedge clock);
   endtask

   // let the block empty out, then give it a few quiet cycles
   task automatic drain_results(input int settle);
      req_tvalid = 1'b0;
      while (due_events.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // result side: ready follows a stall pattern that changes every so often
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(8, 64);
      end
      stall_left = stall_left - 1;
      case (stall_mode)
         STALL_NONE:   rsp_tready <= 1'b1;
         STALL_HALF:   rsp_tready <= ($urandom_range(0, 1) == 0);
         STALL_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // compare every accepted result with the oldest one still due
   always @(posedge clock) begin : check_results
      cif_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_checked++;
         if (due_events.size() == 0)
            report_mismatch("result with nothing due", rsp_tdata[63:0], 64'd0);
         else begin
            want = due_events.pop_front();
            if (rsp_tuser[0] !== want.event_kind)
               report_mismatch("event kind", 64'(rsp_tuser[0]), 64'(want.event_kind));
            if (rsp_tdata[63:0] !== want.token_value)
               report_mismatch("token value", rsp_tdata[63:0], want.token_value);
            if (rsp_tdata[65:64] !== want.card_status)
               report_mismatch("card status", 64'(rsp_tdata[65:64]), 64'(want.card_status));
            if (rsp_tdata[129:66] !== want.card_fold)
               report_mismatch("byte fold", rsp_tdata[129:66], want.card_fold);
            if (rsp_tdata[140:130] !== want.card_bytes)
               report_mismatch("byte count", 64'(rsp_tdata[140:130]), 64'(want.card_bytes));
            if (rsp_tdata[143:141] !== 3'd0)
               report_mismatch("padding bits", 64'(rsp_tdata[143:141]), 64'd0);
            if (rsp_tlast !== want.last)
               report_mismatch("last flag", 64'(rsp_tlast), 64'(want.last));
         end
      end
   end

   // hard stop for a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles, %0d results still due",
                   cycle_count, due_events.size());
         $display("tb: FAIL");
         $finish;
      end
   end

   // append an ascii string to the card being built
   function automatic void append_text(input string s);
      for (int j = 0; j < s.len(); j++)
         card_text.push_back(s[j]);
   endfunction

   function automatic logic [7:0] pick_space();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int          phase;
      int          phase_start;
      int          rand_target;
      int          ntok;
      int          kind;
      int          pos;
      logic        glue;
      logic        long_done;
      logic [10:0] lim_now;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = cif_pkg::FUNC_DATA;
      csr_valid  = 1'b0;
      csr_wdata  = 11'd0;
      limit_shadow = cif_pkg::CARD_LIMIT_RESET;
      clear_card();
      long_done = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // opening script, reset limit in force
      foreach (opening_script[i])
         send_request(opening_script[i].func, opening_script[i].octet,
                      opening_script[i].pin, opening_script[i].want);

      // random cards, one card limit per phase
      rand_target = n_requests + RANDOM_ITEMS;
      phase = 0;
      while (phase < 8 || n_requests < rand_target) begin
         // the limit only changes with the block idle and between cards
         drain_results(4);
         lim_now = (phase < 8) ? phase_limits[phase] : 11'($urandom_range(1, 40));
         csr_valid = 1'b1;
         csr_wdata = lim_now;
         do @(posedge clock); while (!csr_ready);
         limit_shadow = lim_now;
         n_limit_writes++;
         @(negedge clock);
         csr_valid = 1'b0;

         phase_start = n_requests;
         while (n_requests - phase_start < PHASE_ITEMS) begin
            card_text.delete();
            if (lim_now == 11'd2047 && !long_done) begin
               // one card past the hard ceiling, count saturates at 1024
               while (card_text.size() < 1030)
                  append_text("-4711 ");
               long_done = 1'b1;
            end else begin
               kind = $urandom_range(0, 9);
               if (kind == 0) begin
                  // plain noise
                  repeat ($urandom_range(0, 12))
                     card_text.push_back(8'($urandom_range(0, 255)));
               end else begin
                  // well-formed card: tokens between runs of whitespace
                  if ($urandom_range(0, 3) == 0)
                     card_text.push_back(pick_space());
                  ntok = $urandom_range(0, 5);
                  glue = 1'b0;
                  for (int k = 0; k < ntok; k++) begin
                     if (glue || $urandom_range(0, 2) == 0)
                        card_text.push_back(CH_MINUS);
                     if ($urandom_range(0, 7) == 0)
                        append_text(extreme_values[$urandom_range(0, 5)]);
                     else
                        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(7, 19)
                                                            : $urandom_range(1, 4))
                           card_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                     // sometimes the next token's minus follows the digits directly
                     glue = ($urandom_range(0, 5) == 0);
                     if (!glue && (k < ntok - 1 || $urandom_range(0, 1) == 1))
                        repeat ($urandom_range(1, 2))
                           card_text.push_back(pick_space());
                  end
                  // a fifth of the cards get one defect
                  if (kind <= 2) begin
                     pos = $urandom_range(0, card_text.size());
                     case ($urandom_range(0, 2))
                        0: card_text.insert(pos, 8'($urandom_range(0, 255)));
                        1: card_text.push_back(CH_MINUS);
                        default: begin
                           card_text.insert(pos, pick_space());
                           card_text.insert(pos, CH_MINUS);
                        end
                     endcase
                  end
               end
            end
            foreach (card_text[k])
               send_request(cif_pkg::FUNC_DATA, card_text[k], PIN_NONE, 64'd0);
            // the octet of a card end is don't-care, so it is random
            send_request(cif_pkg::FUNC_END, 8'($urandom_range(0, 255)), PIN_NONE, 64'd0);
         end
         phase++;
      end

      drain_results(8);

      $display("tb: %0d requests, %0d results checked: %0d tokens, %0d card summaries",
               n_requests, n_checked, n_tokens, n_summaries);
      $display("tb: %0d cards over the limit, %0d with a parse failure, %0d limit writes",
               n_oversize, n_parse_fail, n_limit_writes);
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

FILE: card_integer_tokenizer_fold.f
sv/cif_pkg.sv
sv/cif_scan.sv
sv/cif_rsp_queue.sv
sv/card_integer_tokenizer_fold.sv
tb/tb.sv
